// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/rsfc_pkg.sv =====
// ---------------------------------------------------------------------------
// rsfc_pkg
// Fixed formats of the ray/sphere far clip block.
// ---------------------------------------------------------------------------
package rsfc_pkg;
	localparam int DIR_W    = 16;  // direction, Q1.14
	localparam int DIR_FRAC = 14;
	localparam int RAD_W    = 31;  // radius, Q31.0 unsigned
	localparam int RR_W     = 2 * RAD_W;
endpackage

// ===== hw/rtl/ray_sphere_far_clip.sv =====
// Pipeline: stages 1 to 5, SW square-root stages, then stages 6 and 7,
//   where SW = max(32, COORD_WIDTH + 6) is the number of square-root stages.
// Throughput: one beat per cycle; the whole pipeline stalls only when the
//   output register holds a beat that is not taken.
// Reset: arst_n clears all valid bits and the radius register to zero.
// ---------------------------------------------------------------------------
// ray_sphere_far_clip
// Far intersection of a ray with a sphere of configurable radius, fully
// pipelined with one restoring square-root stage per result bit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_sphere_far_clip import rsfc_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	// radius write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [RAD_W-1:0] cfg_data,   // sphere_radius
	// input rays
	input  logic s_tvalid,
	output logic s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y, center_z
	input  logic [((6*COORD_WIDTH+3*DIR_W+7)/8)*8-1:0] s_tdata,
	// results
	output logic m_tvalid,
	input  logic m_tready,
	// point_x, point_y, point_z
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic [0:0] m_tuser                  // hit
);
	localparam int W   = COORD_WIDTH;
	localparam int VW  = W + 1;               // v = c - o
	localparam int PDW = VW + DIR_W;          // v * d
	localparam int DTW = PDW + 2;             // dot sum
	localparam int TW  = DTW - DIR_FRAC;      // t
	localparam int VVW = 2 * VW + 2;          // |v|^2
	localparam int SW  = (W + 6 > 32) ? W + 6 : 32;
	localparam int XW  = 2 * SW;              // radicand
	localparam int DW  = XW + 2;              // signed compare width
	localparam int LW  = SW + 1;              // t + s
	localparam int LPW = LW + 1 + DIR_W;      // (t + s) * d
	localparam int ODW = ((3*W+7)/8)*8;

	typedef struct packed {
		logic                   ok;
		logic signed [TW-1:0]   t;
		logic [3*W-1:0]         o;
		logic [3*DIR_W-1:0]     d;
	} side_t;

	logic [RAD_W-1:0] radius_q;
	logic ce;

	// radius register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) radius_q <= '0;
		else if (cfg_valid) radius_q <= cfg_data;
	end

	// whole pipe advances unless the output beat is stuck
	assign ce       = !m_tvalid || m_tready;
	assign s_tready = ce;

	// stage 1: v = c - o
	logic                    vld_s1;
	logic signed [VW-1:0]    v_s1 [3];
	logic signed [DIR_W-1:0] d_s1 [3];
	logic [3*W-1:0]          o_s1;
	logic [3*DIR_W-1:0]      draw_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (ce) vld_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				v_s1[i] <= VW'($signed(s_tdata[3*W+3*DIR_W+i*W +: W]))
					- VW'($signed(s_tdata[i*W +: W]));
				d_s1[i] <= $signed(s_tdata[3*W+i*DIR_W +: DIR_W]);
			end
			o_s1    <= s_tdata[3*W-1:0];
			draw_s1 <= s_tdata[3*W +: 3*DIR_W];
		end
	end

	// stage 2: products v*d and v*v
	logic                  vld_s2;
	logic signed [PDW-1:0] vd_s2 [3];
	logic signed [2*VW-1:0] vv_s2 [3];
	logic [3*W-1:0]        o_s2;
	logic [3*DIR_W-1:0]    d_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (ce) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				vd_s2[i] <= PDW'(v_s1[i]) * PDW'(d_s1[i]);
				vv_s2[i] <= (2*VW)'(v_s1[i]) * (2*VW)'(v_s1[i]);
			end
			o_s2 <= o_s1;
			d_s2 <= draw_s1;
		end
	end

	// stage 3: dot product and |v|^2
	logic                  vld_s3;
	logic signed [DTW-1:0] dot_s3;
	logic [VVW-1:0]        vv_s3;
	logic [3*W-1:0]        o_s3;
	logic [3*DIR_W-1:0]    d_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (ce) vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			dot_s3 <= DTW'(vd_s2[0]) + DTW'(vd_s2[1]) + DTW'(vd_s2[2]);
			vv_s3  <= VVW'(unsigned'(vv_s2[0])) + VVW'(unsigned'(vv_s2[1]))
				+ VVW'(unsigned'(vv_s2[2]));
			o_s3 <= o_s2;
			d_s3 <= d_s2;
		end
	end

	// stage 4: t = floor(dot / 2^14), t^2, r^2
	logic                   vld_s4;
	logic                   neg_s4;
	logic signed [TW-1:0]   t_s4;
	logic signed [2*TW-1:0] tt_s4;
	logic [RR_W-1:0]        rr_s4;
	logic [VVW-1:0]         vv_s4;
	logic [3*W-1:0]         o_s4;
	logic [3*DIR_W-1:0]     d_s4;
	logic signed [TW-1:0]   t_s3;
	assign t_s3 = dot_s3[DTW-1:DIR_FRAC];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (ce) vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			neg_s4 <= dot_s3[DTW-1];
			t_s4   <= t_s3;
			tt_s4  <= (2*TW)'(t_s3) * (2*TW)'(t_s3);
			rr_s4  <= RR_W'(radius_q) * RR_W'(radius_q);
			vv_s4  <= vv_s3;
			o_s4   <= o_s3;
			d_s4   <= d_s3;
		end
	end

	// stage 5: perpendicular distance test and radicand
	logic signed [DW-1:0] perp_c, rr_c, rad_c;
	assign perp_c = $signed({{(DW-VVW){1'b0}}, vv_s4}) - DW'(tt_s4);
	assign rr_c   = $signed({{(DW-RR_W){1'b0}}, rr_s4});
	assign rad_c  = rr_c - perp_c;

	logic            vld_s5;
	logic [XW-1:0]   rad_s5;
	side_t           side_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (ce) vld_s5 <= vld_s4;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			rad_s5     <= rad_c[XW-1:0];
			side_s5.ok <= !neg_s4 && (perp_c <= rr_c);
			side_s5.t  <= t_s4;
			side_s5.o  <= o_s4;
			side_s5.d  <= d_s4;
		end
	end

	// square-root stages: one result bit per stage
	logic          vld_sq [SW];
	logic [XW-1:0] rem_sq [SW];
	logic [XW-1:0] res_sq [SW];
	side_t         side_sq [SW];

	for (genvar k = 0; k < SW; k++) begin : g_sqrt
		localparam logic [XW-1:0] ONE = XW'(1) << (2*(SW-1-k));
		logic          vld_in;
		logic [XW-1:0] rem_in, res_in, trial;
		side_t         side_in;
		if (k == 0) begin : g_first
			assign vld_in  = vld_s5;
			assign rem_in  = rad_s5;
			assign res_in  = '0;
			assign side_in = side_s5;
		end else begin : g_next
			assign vld_in  = vld_sq[k-1];
			assign rem_in  = rem_sq[k-1];
			assign res_in  = res_sq[k-1];
			assign side_in = side_sq[k-1];
		end
		assign trial = res_in + ONE;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sq[k] <= 1'b0;
			else if (ce) vld_sq[k] <= vld_in;
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				side_sq[k] <= side_in;
				if (rem_in >= trial) begin
					rem_sq[k] <= rem_in - trial;
					res_sq[k] <= (res_in >> 1) + ONE;
				end else begin
					rem_sq[k] <= rem_in;
					res_sq[k] <= res_in >> 1;
				end
			end
		end
	end

	// stage 6: (t + s) * d
	side_t               side_e;
	logic signed [LW:0]  len_c;
	assign side_e = side_sq[SW-1];
	assign len_c  = $signed({2'b00, res_sq[SW-1][SW-1:0]}) + (LW+1)'(side_e.t);

	logic                  vld_s6;
	logic                  ok_s6;
	logic signed [LPW-1:0] lp_s6 [3];
	logic [3*W-1:0]        o_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (ce) vld_s6 <= vld_sq[SW-1];
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++)
				lp_s6[i] <= LPW'(len_c) * LPW'($signed(side_e.d[i*DIR_W +: DIR_W]));
			ok_s6 <= side_e.ok;
			o_s6  <= side_e.o;
		end
	end

	// stage 7: output register, point = o + floor(len*d / 2^14) on a hit, zero on a miss
	logic           vld_s7;
	logic           hit_s7;
	logic [3*W-1:0] pt_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (ce) vld_s7 <= vld_s6;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			hit_s7 <= ok_s6;
			for (int i = 0; i < 3; i++)
				pt_s7[i*W +: W] <= ok_s6
					? o_s6[i*W +: W] + lp_s6[i][DIR_FRAC +: W] : '0;
		end
	end

	assign m_tvalid = vld_s7;
	assign m_tuser  = hit_s7;
	assign m_tdata  = ODW'(pt_s7);

	// checks
	`ASSERT_AT(a_miss_zero, clk, arst_n, (m_tvalid && !m_tuser[0]) |-> (pt_s7 == '0))
	`ASSERT_AT(a_stall_hold, clk, arst_n, !ce |=> ($stable(vld_s5) && $stable(vld_s6)))
	`ASSERT_NEVER(a_rad_sign, clk, arst_n, vld_s5 && side_s5.ok && rad_s5[XW-1])
endmodule
